// ===== hw/rtl/pcbn_pkg.sv =====
// Shared types and constants of the per-class box suppression block.
package pcbn_pkg;

   localparam int CLASS_BITS  = 8;
   localparam int THR_BITS    = 17;
   localparam int FRAC_BITS   = 16;
   localparam int NUMBER_BITS = 16;

   localparam logic [THR_BITS-1:0]    THR_RESET  = 17'd29491;
   localparam logic [NUMBER_BITS-1:0] NUMBER_MAX = 16'hFFFF;

   // tag that travels with one kept-box read into the overlap pipeline
   typedef struct packed {
      logic valid;
      logic match;   // same class as the candidate
   } pcbn_ctl_type;

   // status returned by the overlap pipeline
   typedef struct packed {
      logic busy;    // a compare is still in flight
      logic hit;     // this cycle's compare is same-class and exceeds the threshold
   } pcbn_res_type;

endpackage

// ===== hw/rtl/pcbn_iou.sv =====
// Pipelined overlap test of the candidate box against one kept box per cycle.
module pcbn_iou
   import pcbn_pkg::*;
#(
   parameter int COORD_BITS = 12
) (
   input  logic                      clock,
   input  logic                      reset,
   input  pcbn_ctl_type              ctl,
   input  logic [COORD_BITS-1:0]     cand_left,
   input  logic [COORD_BITS-1:0]     cand_top,
   input  logic [COORD_BITS:0]       cand_right,
   input  logic [COORD_BITS:0]       cand_bottom,
   input  logic [2*COORD_BITS+1:0]   cand_area,
   input  logic [COORD_BITS-1:0]     kept_left,
   input  logic [COORD_BITS-1:0]     kept_top,
   input  logic [COORD_BITS:0]       kept_right,
   input  logic [COORD_BITS:0]       kept_bottom,
   input  logic [THR_BITS-1:0]       thr,
   output pcbn_res_type              res
);

   localparam int EXT_W  = COORD_BITS + 1;
   localparam int AREA_W = 2 * EXT_W;
   localparam int UNI_W  = AREA_W + 1;
   localparam int PROD_W = THR_BITS + UNI_W;

   logic [EXT_W-1:0]  lo_x, hi_x, lo_y, hi_y;
   logic [EXT_W-1:0]  iw_in, ih_in, wb_in, hb_in;
   logic [EXT_W-1:0]  iw_ff, ih_ff, wb_ff, hb_ff;
   logic              v1_ff, m1_ff, v2_ff, m2_ff, v3_ff, m3_ff, v4_ff, m4_ff;
   logic [AREA_W-1:0] inter2_in, inter2_ff, areab2_in, areab2_ff;
   logic [AREA_W-1:0] inter3_ff, inter4_ff;
   logic [UNI_W-1:0]  uni3_in, uni3_ff;
   logic [PROD_W-1:0] prod4_in, prod4_ff, lhs4;
   logic              nz4_ff;

   // stage 1: overlap extents and kept box size
   always_comb begin
      lo_x = ({1'b0, cand_left} > {1'b0, kept_left}) ? {1'b0, cand_left} : {1'b0, kept_left};
      hi_x = (cand_right < kept_right) ? cand_right : kept_right;
      lo_y = ({1'b0, cand_top} > {1'b0, kept_top}) ? {1'b0, cand_top} : {1'b0, kept_top};
      hi_y = (cand_bottom < kept_bottom) ? cand_bottom : kept_bottom;
      iw_in = (hi_x > lo_x) ? (hi_x - lo_x) : '0;
      ih_in = (hi_y > lo_y) ? (hi_y - lo_y) : '0;
      wb_in = kept_right - {1'b0, kept_left};
      hb_in = kept_bottom - {1'b0, kept_top};
   end

   // stage 2: intersection and kept area; stage 3: union; stage 4: threshold product
   assign inter2_in = AREA_W'(iw_ff) * AREA_W'(ih_ff);
   assign areab2_in = AREA_W'(wb_ff) * AREA_W'(hb_ff);
   assign uni3_in   = UNI_W'(cand_area) + UNI_W'(areab2_ff) - UNI_W'(inter2_ff);
   assign prod4_in  = PROD_W'(thr) * PROD_W'(uni3_ff);

   always_ff @(posedge clock) begin
      iw_ff     <= iw_in;
      ih_ff     <= ih_in;
      wb_ff     <= wb_in;
      hb_ff     <= hb_in;
      m1_ff     <= ctl.match;
      inter2_ff <= inter2_in;
      areab2_ff <= areab2_in;
      m2_ff     <= m1_ff;
      uni3_ff   <= uni3_in;
      inter3_ff <= inter2_ff;
      m3_ff     <= m2_ff;
      prod4_ff  <= prod4_in;
      inter4_ff <= inter3_ff;
      nz4_ff    <= (uni3_ff != '0);
      m4_ff     <= m3_ff;
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= ctl.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   // i * 2^16 > t * u, only for a positive union
   assign lhs4     = PROD_W'({inter4_ff, {FRAC_BITS{1'b0}}});
   assign res.hit  = v4_ff & m4_ff & nz4_ff & (lhs4 > prod4_ff);
   assign res.busy = v1_ff | v2_ff | v3_ff | v4_ff;

endmodule

// ===== hw/rtl/per_class_box_nms.sv =====
// Top level of the greedy per-class box suppression block.
// Operation: after an item is accepted, the kept boxes are read one per cycle from the
//   kept-box memory, then pass through a 4-stage overlap pipeline to the result.
// Items are taken one at a time, the next once the last result is registered; a result
//   still waiting in the output register holds the next item in the finish state.
// Reset (synchronous): control, fill count and position cleared, threshold set to 29491;
//   the kept-box memory is not cleared, an empty fill count makes it read as empty.
module per_class_box_nms
   import pcbn_pkg::*;
#(
   parameter int MAX_KEPT   = 256,
   parameter int COORD_BITS = 12,
   localparam int REQ_DATA_W = ((4 * COORD_BITS + CLASS_BITS + 7) / 8) * 8
) (
   input  logic                   clock,
   input  logic                   reset,
   // req_tdata: box_left, box_top, box_width, box_height, class_id, zero pad
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   // req_tuser: start_of_frame
   input  logic                   req_tuser,
   // rsp_tdata: box_number
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [NUMBER_BITS-1:0] rsp_tdata,
   // rsp_tuser: kept, store_overflow
   output logic [1:0]             rsp_tuser,
   // threshold register write
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [THR_BITS-1:0]    csr_data
);

   localparam int CB      = COORD_BITS;
   localparam int EXT_W   = CB + 1;
   localparam int AREA_W  = 2 * EXT_W;
   localparam int ADDR_W  = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
   localparam int CNT_W   = $clog2(MAX_KEPT + 1);
   localparam int ENTRY_W = 2 * CB + 2 * EXT_W + CLASS_BITS;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;

   logic [THR_BITS-1:0]    thr_ff, thr_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [CNT_W-1:0]       iss_ff, iss_in;
   logic [NUMBER_BITS-1:0] pos_ff, pos_in;
   logic [NUMBER_BITS-1:0] number_ff, number_in;
   logic                   hit_ff, hit_in;
   logic                   rd_v_ff, rd_v_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_kept_ff, rsp_kept_in;
   logic                   rsp_ovf_ff, rsp_ovf_in;
   logic [NUMBER_BITS-1:0] rsp_number_ff, rsp_number_in;

   // candidate box, held for the whole scan
   logic [CB-1:0]          cand_left_ff, cand_left_in;
   logic [CB-1:0]          cand_top_ff, cand_top_in;
   logic [EXT_W-1:0]       cand_right_ff, cand_right_in;
   logic [EXT_W-1:0]       cand_bottom_ff, cand_bottom_in;
   logic [CLASS_BITS-1:0]  cand_class_ff, cand_class_in;
   logic [AREA_W-1:0]      cand_area_ff, cand_area_in;

   // kept-box memory: {class, bottom, right, top, left}
   logic [ENTRY_W-1:0]     mem [MAX_KEPT];
   logic [ENTRY_W-1:0]     mem_q_ff;
   logic                   mem_we;
   logic [ENTRY_W-1:0]     mem_wdata;

   logic [CB-1:0]          in_left, in_top, in_width, in_height;
   logic [CLASS_BITS-1:0]  in_class;
   logic [NUMBER_BITS-1:0] base_number;
   logic                   req_fire, rsp_fire, csr_fire;
   logic                   keep, room;

   logic [CB-1:0]          kept_left, kept_top;
   logic [EXT_W-1:0]       kept_right, kept_bottom;
   logic [CLASS_BITS-1:0]  kept_class;
   pcbn_ctl_type           iou_ctl;
   pcbn_res_type           iou_res;

   assign in_left   = req_tdata[CB-1:0];
   assign in_top    = req_tdata[2*CB-1:CB];
   assign in_width  = req_tdata[3*CB-1:2*CB];
   assign in_height = req_tdata[4*CB-1:3*CB];
   assign in_class  = req_tdata[4*CB+CLASS_BITS-1:4*CB];

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign req_fire   = req_tvalid & req_tready;
   assign rsp_fire   = rsp_valid_ff & rsp_tready;
   assign csr_fire   = csr_valid & csr_ready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_number_ff;
   assign rsp_tuser  = {rsp_ovf_ff, rsp_kept_ff};

   // unpack the kept box read last cycle
   assign kept_left   = mem_q_ff[CB-1:0];
   assign kept_top    = mem_q_ff[2*CB-1:CB];
   assign kept_right  = mem_q_ff[2*CB+EXT_W-1:2*CB];
   assign kept_bottom = mem_q_ff[2*CB+2*EXT_W-1:2*CB+EXT_W];
   assign kept_class  = mem_q_ff[ENTRY_W-1:2*CB+2*EXT_W];

   assign iou_ctl.valid = rd_v_ff;
   assign iou_ctl.match = (kept_class == cand_class_ff);

   assign mem_wdata = {cand_class_ff, cand_bottom_ff, cand_right_ff, cand_top_ff, cand_left_ff};
   assign keep      = ~hit_ff;
   assign room      = (count_ff < CNT_W'(MAX_KEPT));

   pcbn_iou #(
      .COORD_BITS (COORD_BITS)
   ) u_iou (
      .clock       (clock),
      .reset       (reset),
      .ctl         (iou_ctl),
      .cand_left   (cand_left_ff),
      .cand_top    (cand_top_ff),
      .cand_right  (cand_right_ff),
      .cand_bottom (cand_bottom_ff),
      .cand_area   (cand_area_ff),
      .kept_left   (kept_left),
      .kept_top    (kept_top),
      .kept_right  (kept_right),
      .kept_bottom (kept_bottom),
      .thr         (thr_ff),
      .res         (iou_res)
   );

   always_comb begin
      state_in       = state_ff;
      thr_in         = csr_fire ? csr_data : thr_ff;
      count_in       = count_ff;
      iss_in         = iss_ff;
      pos_in         = pos_ff;
      number_in      = number_ff;
      hit_in         = hit_ff | iou_res.hit;   // any same-class overlap drops the box
      rd_v_in        = 1'b0;
      rsp_valid_in   = rsp_valid_ff & ~rsp_fire;
      rsp_kept_in    = rsp_kept_ff;
      rsp_ovf_in     = rsp_ovf_ff;
      rsp_number_in  = rsp_number_ff;
      cand_left_in   = cand_left_ff;
      cand_top_in    = cand_top_ff;
      cand_right_in  = cand_right_ff;
      cand_bottom_in = cand_bottom_ff;
      cand_class_in  = cand_class_ff;
      cand_area_in   = cand_area_ff;
      mem_we         = 1'b0;
      base_number    = req_tuser ? '0 : pos_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_tuser) begin
                  count_in = '0;
               end
               number_in      = base_number;
               pos_in         = (base_number == NUMBER_MAX) ? base_number
                                                            : base_number + 1'b1;
               cand_left_in   = in_left;
               cand_top_in    = in_top;
               cand_right_in  = EXT_W'(in_left) + EXT_W'(in_width);
               cand_bottom_in = EXT_W'(in_top) + EXT_W'(in_height);
               cand_class_in  = in_class;
               cand_area_in   = AREA_W'(in_width) * AREA_W'(in_height);
               iss_in         = '0;
               hit_in         = 1'b0;
               state_in       = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // one kept box read per cycle
            if (iss_ff < count_ff) begin
               rd_v_in = 1'b1;
               iss_in  = iss_ff + 1'b1;
            end else begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!rd_v_ff && !iou_res.busy) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               if (keep && room) begin
                  mem_we   = 1'b1;
                  count_in = count_ff + 1'b1;
               end
               rsp_valid_in  = 1'b1;
               rsp_kept_in   = keep;
               rsp_ovf_in    = keep & ~room;
               rsp_number_in = number_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      number_ff      <= number_in;
      iss_ff         <= iss_in;
      rsp_kept_ff    <= rsp_kept_in;
      rsp_ovf_ff     <= rsp_ovf_in;
      rsp_number_ff  <= rsp_number_in;
      cand_left_ff   <= cand_left_in;
      cand_top_ff    <= cand_top_in;
      cand_right_ff  <= cand_right_in;
      cand_bottom_ff <= cand_bottom_in;
      cand_class_ff  <= cand_class_in;
      cand_area_ff   <= cand_area_in;
      hit_ff         <= hit_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         thr_ff       <= THR_RESET;
         count_ff     <= '0;
         pos_ff       <= '0;
         rd_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         thr_ff       <= thr_in;
         count_ff     <= count_in;
         pos_ff       <= pos_in;
         rd_v_ff      <= rd_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // kept-box memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[count_ff[ADDR_W-1:0]] <= mem_wdata;
      end
      mem_q_ff <= mem[iss_ff[ADDR_W-1:0]];
   end

endmodule

// ===== hw/rtl/pcbn_checker.sv =====
// Port-level checks of the box suppression block, bound to the top level.
module pcbn_checker
   import pcbn_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [NUMBER_BITS-1:0] rsp_tdata,
   input logic [1:0]             rsp_tuser
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // overflow only on a kept box
   a_ovf_kept: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[1] && !rsp_tuser[0]))
      else $error("overflow flagged on a dropped box");

   // no result straight after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result present after reset");

   // an accepted item keeps the block busy for the following cycle
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second item taken while scanning");

endmodule

bind per_class_box_nms pcbn_checker u_pcbn_checker (.*);
